>>> rtl/core/lsr_pkg.sv
package lsr_pkg;

  // widest literal the 64-bit byte registers can carry
  localparam int unsigned MaxBytes = 8;
  localparam int unsigned CntW     = 4;

  typedef enum logic [1:0] {
    CFG_PATTERN_BYTES  = 2'd0,
    CFG_PATTERN_LENGTH = 2'd1,
    CFG_REPLACE_BYTES  = 2'd2,
    CFG_REPLACE_LENGTH = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       text_done;
  } out_beat_t;

  // control handed along the window row
  typedef struct packed {
    logic            take;
    logic            shift;
    logic [CntW-1:0] count;
    logic [CntW-1:0] len;
  } win_ctrl_t;

  // control handed along the output queue
  typedef struct packed {
    logic            take;
    logic            pop;
    logic            base;
    logic [CntW-1:0] n_new;
  } que_ctrl_t;

endpackage

>>> rtl/core/lsr_win_cell.sv
module lsr_win_cell
  import lsr_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic      clk_i,
  input  win_ctrl_t ctrl_i,
  input  logic [7:0] text_byte_i,
  input  logic [7:0] pat_byte_i,
  input  logic [7:0] nb_byte_i,
  output logic [7:0] cur_byte_o,
  output logic       hit_o
);

  localparam logic [CntW-1:0] Pos = CntW'(IDX);

  logic [7:0] byte_q, byte_d;

  // window view with the incoming byte appended
  assign cur_byte_o = (Pos < ctrl_i.count) ? byte_q : text_byte_i;

  // cells past the pattern length always agree
  assign hit_o = (Pos >= ctrl_i.len) || (cur_byte_o == pat_byte_i);

  // shift towards the oldest slot on a full-window miss, else load the view
  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.take) begin
      byte_d = ctrl_i.shift ? nb_byte_i : cur_byte_o;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule

>>> rtl/core/lsr_out_cell.sv
module lsr_out_cell
  import lsr_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic      clk_i,
  input  que_ctrl_t ctrl_i,
  input  out_beat_t new0_i,
  input  out_beat_t new1_i,
  input  out_beat_t up_i,
  output out_beat_t beat_o
);

  localparam logic [CntW-1:0] Pos = CntW'(IDX);

  out_beat_t beat_q, beat_d;
  logic      in_range;
  logic [CntW-1:0] base_w;

  assign base_w   = {{(CntW-1){1'b0}}, ctrl_i.base};
  assign in_range = ctrl_i.take && (Pos >= base_w) && ((Pos - base_w) < ctrl_i.n_new);

  // load a new beat, else move up one place on a pop
  always_comb begin
    beat_d = beat_q;
    if (in_range) begin
      beat_d = ctrl_i.base ? new1_i : new0_i;
    end else if (ctrl_i.pop) begin
      beat_d = up_i;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  assign beat_o = beat_q;

endmodule

>>> rtl/core/literal_substring_replacer.sv
// Streaming literal replace: every leftmost, non-overlapping match of the pattern
// (pattern_length bytes, 1..8) in the byte stream is replaced by replace_length bytes
// (0..8, zero deletes). A row of window cells holds the bytes that may still start a
// match and compares them against the pattern in the cycle a byte arrives; the results
// go into a queue of output cells and leave one beat per cycle unless stalled. An input
// byte is taken in the same cycle it is offered whenever at most one result beat would
// remain queued, so an unstalled stream in which each byte yields one beat runs at one
// byte per cycle; a byte that yields n beats (a replacement, or the flush at end of text)
// with n above two (above one if a beat is still queued) stalls the input while the queue
// drains. A byte that yields nothing gives a bare marker beat. Write the configuration
// only while the block is empty; writing pattern_length discards the held window.
module literal_substring_replacer
  import lsr_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 8,
  parameter int unsigned MAX_REPLACE = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  cfg_reg_e    cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_beat_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_beat_t   out_data_o
);

  localparam int unsigned NumWin = (MAX_PATTERN < MaxBytes) ? MAX_PATTERN : MaxBytes;
  localparam int unsigned NumRep = (MAX_REPLACE < MaxBytes) ? MAX_REPLACE : MaxBytes;
  localparam int unsigned NumRes = (NumWin > NumRep) ? NumWin : NumRep;
  localparam int unsigned Depth  = NumRes + 1;
  localparam logic [CntW-1:0] WinLim = CntW'(NumWin);
  localparam logic [CntW-1:0] RepLim = CntW'(NumRep);

  // configuration registers
  logic [63:0]     pat_q, rep_q;
  logic [CntW-1:0] pat_len_q, rep_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q     <= '0;
      pat_len_q <= CntW'(1);
      rep_q     <= '0;
      rep_len_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PATTERN_BYTES:  pat_q     <= cfg_data_i;
        CFG_PATTERN_LENGTH: pat_len_q <= cfg_data_i[CntW-1:0];
        CFG_REPLACE_BYTES:  rep_q     <= cfg_data_i;
        CFG_REPLACE_LENGTH: rep_len_q <= cfg_data_i[CntW-1:0];
      endcase
    end
  end

  // saturated lengths
  logic [CntW-1:0] len_eff, rep_eff;
  assign len_eff = (pat_len_q == '0) ? CntW'(1) :
                   (pat_len_q > WinLim) ? WinLim : pat_len_q;
  assign rep_eff = (rep_len_q > RepLim) ? RepLim : rep_len_q;

  // handshakes
  logic [CntW-1:0] occ_q, occ_d, occ_after;
  logic            pop, take;

  assign out_valid_o = (occ_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign occ_after   = occ_q - {{(CntW-1){1'b0}}, pop};
  assign in_stall_o  = (occ_after > CntW'(1));
  assign take        = in_valid_i && !in_stall_o;

  // window row
  logic [CntW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [7:0]      win_byte [NumWin];
  logic [NumWin-1:0] win_hit;
  logic            full, match, shift;
  win_ctrl_t       wctrl;

  assign cnt_inc = cnt_q + CntW'(1);
  assign full    = (cnt_inc == len_eff);
  assign match   = full && (&win_hit);
  assign shift   = full && !match && !in_data_i.end_of_text;

  assign wctrl.take  = take;
  assign wctrl.shift = shift;
  assign wctrl.count = cnt_q;
  assign wctrl.len   = len_eff;

  for (genvar gi = 0; gi < NumWin; gi++) begin : g_win
    logic [7:0] nb;
    if (gi + 1 < NumWin) begin : g_nb
      assign nb = win_byte[gi+1];
    end else begin : g_end
      assign nb = '0;
    end
    lsr_win_cell #(.IDX(gi)) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (wctrl),
      .text_byte_i(in_data_i.text_byte),
      .pat_byte_i (pat_q[8*gi +: 8]),
      .nb_byte_i  (nb),
      .cur_byte_o (win_byte[gi]),
      .hit_o      (win_hit[gi])
    );
  end

  // held count
  always_comb begin
    cnt_d = cnt_q;
    if (cfg_we_i && (cfg_idx_i == CFG_PATTERN_LENGTH)) begin
      cnt_d = '0;
    end else if (take) begin
      if (match || in_data_i.end_of_text) begin
        cnt_d = '0;
      end else if (shift) begin
        cnt_d = len_eff - CntW'(1);
      end else begin
        cnt_d = cnt_inc;
      end
    end
  end

  // beats caused by this byte
  logic [CntW-1:0] n_bytes, n_eff;
  always_comb begin
    if (match) begin
      n_bytes = rep_eff;
    end else if (in_data_i.end_of_text) begin
      n_bytes = cnt_inc;
    end else if (full) begin
      n_bytes = CntW'(1);
    end else begin
      n_bytes = '0;
    end
  end
  assign n_eff = (n_bytes == '0) ? CntW'(1) : n_bytes;

  out_beat_t res [NumRes];
  for (genvar gk = 0; gk < NumRes; gk++) begin : g_res
    logic [7:0] wb, rb;
    if (gk < NumWin) begin : g_w
      assign wb = win_byte[gk];
    end else begin : g_nw
      assign wb = '0;
    end
    if (gk < NumRep) begin : g_r
      assign rb = rep_q[8*gk +: 8];
    end else begin : g_nr
      assign rb = '0;
    end
    always_comb begin
      res[gk].byte_valid  = (n_bytes != '0);
      res[gk].out_byte    = (n_bytes == '0) ? 8'd0 : (match ? rb : wb);
      res[gk].last_of_run = (CntW'(gk) == (n_eff - CntW'(1)));
      res[gk].text_done   = res[gk].last_of_run && in_data_i.end_of_text;
    end
  end

  // output queue, cell 0 at the head
  que_ctrl_t qctrl;
  out_beat_t qbeat [Depth];

  assign qctrl.take  = take;
  assign qctrl.pop   = pop;
  assign qctrl.base  = occ_after[0];
  assign qctrl.n_new = n_eff;

  for (genvar gq = 0; gq < Depth; gq++) begin : g_que
    out_beat_t n0, n1, up;
    if (gq < NumRes) begin : g_n0
      assign n0 = res[gq];
    end else begin : g_z0
      assign n0 = '0;
    end
    if (gq >= 1) begin : g_n1
      assign n1 = res[gq-1];
    end else begin : g_z1
      assign n1 = '0;
    end
    if (gq + 1 < Depth) begin : g_up
      assign up = qbeat[gq+1];
    end else begin : g_top
      assign up = '0;
    end
    lsr_out_cell #(.IDX(gq)) u_cell (
      .clk_i (clk_i),
      .ctrl_i(qctrl),
      .new0_i(n0),
      .new1_i(n1),
      .up_i  (up),
      .beat_o(qbeat[gq])
    );
  end

  assign out_data_o = qbeat[0];
  assign occ_d      = occ_after + (take ? n_eff : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      cnt_q <= '0;
    end else begin
      occ_q <= occ_d;
      cnt_q <= cnt_d;
    end
  end

  // queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni) occ_q <= CntW'(Depth))
    else $error("output queue overfilled");

  // held window stays below the pattern length between bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q < len_eff)
    else $error("held window reached pattern length");

  // a taken byte always leaves at least one beat queued
  assert property (@(posedge clk_i) disable iff (!rst_ni) take |=> occ_q != '0)
    else $error("taken byte produced no beat");

  // a run is queued whole, so a head beat that is not last has company
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_of_run |-> occ_q >= CntW'(2))
    else $error("run split across queue refill");

endmodule
